// ----- hdl/tlem_pkg.sv -----
// ----------------------------------------------------------------------------
// tlem_pkg
// Shared types and constants of the text line extent measurement block.
// ----------------------------------------------------------------------------
package tlem_pkg;

	// Defaults of the top-level parameters.
	localparam int GLYPHS_DEF   = 256;
	localparam int PEN_BITS_DEF = 24;

	// Fixed field widths.
	localparam int OUT_W    = 24;
	localparam int HEIGHT_W = 32;
	localparam int CODE_W   = 21;
	localparam int LC_W     = 16;
	localparam int ADV_W    = 18;
	localparam int CFG_W    = 16;

	// Request opcodes.
	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_CHAR = 2'd1;
	localparam logic [1:0] OP_EOL  = 2'd2;

	// Result kinds.
	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_LINE = 2'd1;
	localparam logic [1:0] KIND_TEXT = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_FONT_HEIGHT = 2'd0;
	localparam logic [1:0] REG_GLYPH_COUNT = 2'd1;
	localparam logic [1:0] REG_X_SCALE     = 2'd2;
	localparam logic [1:0] REG_Y_SCALE     = 2'd3;

	// Codes with a fixed advance derived from the cell height.
	localparam logic [CODE_W-1:0] CODE_SPACE = 21'h00020;
	localparam logic [CODE_W-1:0] CODE_NBSP  = 21'h000A0;

	// Operation of the scale unit.
	localparam logic [1:0] MODE_SPACING = 2'd0; // spacing * x_scale / 256
	localparam logic [1:0] MODE_SPACE   = 2'd1; // height * x_scale / 1152
	localparam logic [1:0] MODE_NBSP    = 2'd2; // height * x_scale / 4608
	localparam logic [1:0] MODE_HEIGHT  = 2'd3; // lines * height * y_scale / 256

	// floor(x / 9) == (x * RECIP9) >> RECIP_SHIFT for every x below 2^21.
	localparam logic [18:0] RECIP9      = 19'd466034;
	localparam int          RECIP_SHIFT = 22;

	typedef struct packed {
		logic [9:0] spacing;
		logic [9:0] width;
	} glyph_entry_t;

	typedef struct packed {
		logic       mul_en;
		logic       div_en;
		logic [1:0] mode;
	} scale_ctl_t;

endpackage

// ----- hdl/text_line_extent_measure.sv -----
// ----------------------------------------------------------------------------
// text_line_extent_measure
// Measures proportional-font text: pen positions, line extents, text size.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                 Payload
//  -------   -----------------------   ------------------------------------------
//  request   req_valid / req_stall     opcode, glyph_index, glyph_width,
//                                      glyph_spacing, char_code, end_of_text
//  result    rsp_valid / rsp_stall     result_kind, pen_x, glyph_visible,
//                                      line_width, text_width, text_height, last
//  config    cfg_we (no wait)          cfg_index, cfg_data
//
// A load request writes the glyph table directly.
// A character or end-of-line request passes through acceptance with the
// glyph table read, the scale multiply, the second stage (shift, reciprocal
// divide or y scale), and the pen accumulate into the result register.
// That chain through the table read and the two multiplier stages sets the
// rate. The result register lets the next request enter while a result
// waits; the block holds in its last step only while that register is full
// and stalled. Reset is asynchronous; the glyph table is not cleared.
//
module text_line_extent_measure #(
	parameter int GLYPHS   = tlem_pkg::GLYPHS_DEF,
	parameter int PEN_BITS = tlem_pkg::PEN_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write port.
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [tlem_pkg::CFG_W-1:0]    cfg_data,
	// Request channel.
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [1:0]                    opcode,
	input  logic [7:0]                    glyph_index,
	input  logic [9:0]                    glyph_width,
	input  logic [9:0]                    glyph_spacing,
	input  logic [tlem_pkg::CODE_W-1:0]   char_code,
	input  logic                          end_of_text,
	// Result channel.
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [1:0]                    result_kind,
	output logic [tlem_pkg::OUT_W-1:0]    pen_x,
	output logic                          glyph_visible,
	output logic [tlem_pkg::OUT_W-1:0]    line_width,
	output logic [tlem_pkg::OUT_W-1:0]    text_width,
	output logic [tlem_pkg::HEIGHT_W-1:0] text_height,
	output logic                          last
);

	localparam int AW    = (GLYPHS > 1) ? $clog2(GLYPHS) : 1;
	localparam int SUM_W = ((PEN_BITS > tlem_pkg::ADV_W) ? PEN_BITS : tlem_pkg::ADV_W) + 1;
	localparam logic [PEN_BITS-1:0] PEN_MAX = {PEN_BITS{1'b1}};
	localparam logic [PEN_BITS-1:0] PEN_ONE = PEN_BITS'(1);
	localparam logic [tlem_pkg::LC_W-1:0] LC_ONE = {{(tlem_pkg::LC_W-1){1'b0}}, 1'b1};

	// Sequencer states.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0] state_q;

	// Configuration registers.
	logic [9:0]  font_height_q;
	logic [8:0]  glyph_count_q;
	logic [15:0] x_scale_q;
	logic [15:0] y_scale_q;

	// Measurement state.
	logic [PEN_BITS-1:0]       pen_q;
	logic [PEN_BITS-1:0]       ext_q;
	logic [PEN_BITS-1:0]       widest_q;
	logic [tlem_pkg::LC_W-1:0] line_count_q;

	// Per-request context.
	logic       eol_q;
	logic       eot_q;
	logic       outside_q;
	logic [1:0] mode_q;
	logic [9:0] width_q;

	// Result register.
	logic                          out_valid_q;
	logic [1:0]                    kind_q;
	logic [tlem_pkg::OUT_W-1:0]    pen_x_q;
	logic                          vis_q;
	logic [tlem_pkg::OUT_W-1:0]    line_width_q;
	logic [tlem_pkg::OUT_W-1:0]    text_width_q;
	logic [tlem_pkg::HEIGHT_W-1:0] text_height_q;
	logic                          last_q;

	logic                   accept;
	logic                   is_load;
	logic                   is_char;
	logic                   is_eol;
	logic [31:0]            idx_ext;
	logic                   code_outside;
	logic [1:0]             mode_d;
	tlem_pkg::glyph_entry_t wr_entry;
	tlem_pkg::glyph_entry_t rd_entry;
	tlem_pkg::scale_ctl_t   sctl;
	logic [15:0]            op_a;
	logic [15:0]            op_b;
	logic [31:0]            scale_res;
	logic                   fin_fire;
	logic                   out_take;

	logic [tlem_pkg::ADV_W-1:0] adv;
	logic [SUM_W-1:0]           sum_w;
	logic [SUM_W-1:0]           sum_a;
	logic [PEN_BITS-1:0]        reach;
	logic [PEN_BITS-1:0]        pen_new;
	logic [PEN_BITS-1:0]        ext_mid;
	logic [PEN_BITS-1:0]        ext_new;
	logic [PEN_BITS-1:0]        widest_new;
	logic [31:0]                pen_ext32;
	logic [31:0]                ext_old32;
	logic [31:0]                ext_new32;
	logic [31:0]                widest32;
	logic [31:0]                widest_new32;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign is_load   = (opcode == tlem_pkg::OP_LOAD);
	assign is_char   = (opcode == tlem_pkg::OP_CHAR);
	assign is_eol    = (opcode == tlem_pkg::OP_EOL);

	// Loads beyond the table depth are dropped.
	assign idx_ext = 32'(glyph_index);
	assign wr_entry.width   = glyph_width;
	assign wr_entry.spacing = glyph_spacing;

	// Codes past the font or past the table change nothing.
	assign code_outside = (32'(char_code) >= 32'(glyph_count_q)) ||
	                      (32'(char_code) >= 32'(GLYPHS));

	always_comb begin
		if (is_eol) begin
			mode_d = tlem_pkg::MODE_HEIGHT;
		end else if (char_code == tlem_pkg::CODE_SPACE) begin
			mode_d = tlem_pkg::MODE_SPACE;
		end else if (char_code == tlem_pkg::CODE_NBSP) begin
			mode_d = tlem_pkg::MODE_NBSP;
		end else begin
			mode_d = tlem_pkg::MODE_SPACING;
		end
	end

	tlem_glyph_ram #(
		.DEPTH (GLYPHS),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (accept && is_load && (idx_ext < 32'(GLYPHS))),
		.wr_addr (idx_ext[AW-1:0]),
		.wr_data (wr_entry),
		.rd_en   (accept && is_char),
		.rd_addr (char_code[AW-1:0]),
		.rd_data (rd_entry)
	);

	// The first multiply runs while the table data is fresh; the line
	// count product for an end of line goes through the same stages.
	always_comb begin
		sctl.mul_en = (state_q == ST_MUL);
		sctl.div_en = (state_q == ST_DIV);
		sctl.mode   = mode_q;
		case (mode_q)
			tlem_pkg::MODE_HEIGHT: begin
				op_a = line_count_q;
				op_b = 16'(font_height_q);
			end
			tlem_pkg::MODE_SPACE,
			tlem_pkg::MODE_NBSP: begin
				op_a = 16'(font_height_q);
				op_b = x_scale_q;
			end
			default: begin
				op_a = 16'(rd_entry.spacing);
				op_b = x_scale_q;
			end
		endcase
	end

	tlem_scale u_scale (
		.clk     (clk),
		.ctl     (sctl),
		.op_a    (op_a),
		.op_b    (op_b),
		.y_scale (y_scale_q),
		.result  (scale_res)
	);

	// Pen accumulate. Both sums saturate at the top of the pen range.
	assign adv   = outside_q ? '0 : scale_res[tlem_pkg::ADV_W-1:0];
	assign sum_w = SUM_W'(pen_q) + SUM_W'(width_q);
	assign sum_a = SUM_W'(pen_q) + SUM_W'(adv);
	assign reach   = (sum_w > SUM_W'(PEN_MAX)) ? PEN_MAX : sum_w[PEN_BITS-1:0];
	assign pen_new = (sum_a > SUM_W'(PEN_MAX)) ? PEN_MAX : sum_a[PEN_BITS-1:0];
	assign ext_mid = (reach > ext_q) ? reach : ext_q;
	assign ext_new = (pen_new > ext_mid) ? pen_new : ext_mid;

	assign widest_new = (ext_q > widest_q) ? ext_q : widest_q;

	// Wide views for masking to the output field width.
	assign pen_ext32    = 32'(pen_q);
	assign ext_old32    = 32'(ext_q);
	assign ext_new32    = 32'(ext_new);
	assign widest32     = 32'(widest_q);
	assign widest_new32 = 32'(widest_new);

	assign out_take = out_valid_q && !rsp_stall;
	assign fin_fire = (state_q == ST_FIN) && (!out_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_height_q <= '0;
			glyph_count_q <= '0;
			x_scale_q     <= 16'd256;
			y_scale_q     <= 16'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				tlem_pkg::REG_FONT_HEIGHT: font_height_q <= cfg_data[9:0];
				tlem_pkg::REG_GLYPH_COUNT: glyph_count_q <= cfg_data[8:0];
				tlem_pkg::REG_X_SCALE:     x_scale_q     <= cfg_data;
				tlem_pkg::REG_Y_SCALE:     y_scale_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer: one request at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (is_char || is_eol)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:  state_q <= ST_DIV;
				ST_DIV:  state_q <= ST_FIN;
				ST_FIN: begin
					if (fin_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request context.
	always_ff @(posedge clk) begin
		if (accept) begin
			eol_q     <= is_eol;
			eot_q     <= end_of_text;
			outside_q <= is_char && code_outside;
			mode_q    <= mode_d;
		end
		if (state_q == ST_MUL) begin
			if (outside_q || (mode_q != tlem_pkg::MODE_SPACING)) begin
				width_q <= '0;
			end else begin
				width_q <= rd_entry.width;
			end
		end
	end

	// Measurement state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_q        <= PEN_ONE;
			ext_q        <= PEN_ONE;
			widest_q     <= '0;
			line_count_q <= '0;
		end else begin
			if (accept && is_eol && (line_count_q != '1)) begin
				line_count_q <= line_count_q + LC_ONE;
			end
			if (fin_fire) begin
				if (eol_q) begin
					pen_q <= PEN_ONE;
					ext_q <= PEN_ONE;
					if (eot_q) begin
						widest_q     <= '0;
						line_count_q <= '0;
					end else begin
						widest_q <= widest_new;
					end
				end else begin
					pen_q <= pen_new;
					ext_q <= ext_new;
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			pen_x_q <= pen_ext32[tlem_pkg::OUT_W-1:0];
			if (eol_q) begin
				kind_q        <= eot_q ? tlem_pkg::KIND_TEXT : tlem_pkg::KIND_LINE;
				vis_q         <= 1'b0;
				line_width_q  <= ext_old32[tlem_pkg::OUT_W-1:0];
				text_width_q  <= widest_new32[tlem_pkg::OUT_W-1:0];
				text_height_q <= eot_q ? scale_res : '0;
				last_q        <= eot_q;
			end else begin
				kind_q        <= tlem_pkg::KIND_CHAR;
				vis_q         <= (width_q != '0);
				line_width_q  <= ext_new32[tlem_pkg::OUT_W-1:0];
				text_width_q  <= widest32[tlem_pkg::OUT_W-1:0];
				text_height_q <= '0;
				last_q        <= 1'b0;
			end
		end
	end

	assign rsp_valid     = out_valid_q;
	assign result_kind   = kind_q;
	assign pen_x         = pen_x_q;
	assign glyph_visible = vis_q;
	assign line_width    = line_width_q;
	assign text_width    = text_width_q;
	assign text_height   = text_height_q;
	assign last          = last_q;

endmodule

// ----- hdl/tlem_glyph_ram.sv -----
// ----------------------------------------------------------------------------
// tlem_glyph_ram
// Glyph table: one write port and one registered read port.
// ----------------------------------------------------------------------------
module tlem_glyph_ram #(
	parameter int DEPTH = tlem_pkg::GLYPHS_DEF,
	parameter int AW    = 8
) (
	input  logic                   clk,
	input  logic                   wr_en,
	input  logic [AW-1:0]          wr_addr,
	input  tlem_pkg::glyph_entry_t wr_data,
	input  logic                   rd_en,
	input  logic [AW-1:0]          rd_addr,
	output tlem_pkg::glyph_entry_t rd_data
);

	tlem_pkg::glyph_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- hdl/tlem_scale.sv -----
// ----------------------------------------------------------------------------
// tlem_scale
// Two-stage scale unit: a product of two operands, then either a shift,
// a division by a constant through a reciprocal, or the y scale product.
// ----------------------------------------------------------------------------
module tlem_scale (
	input  logic                 clk,
	input  tlem_pkg::scale_ctl_t ctl,
	input  logic [15:0]          op_a,
	input  logic [15:0]          op_b,
	input  logic [15:0]          y_scale,
	output logic [31:0]          result
);

	logic [31:0] prod_s1;
	logic [1:0]  mode_s1;
	logic [31:0] res_s2;
	logic [25:0] x2;
	logic [18:0] m2;
	logic [44:0] prod2;
	logic [36:0] height_sh;
	logic [31:0] res_d;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= 32'(op_a) * 32'(op_b);
			mode_s1 <= ctl.mode;
		end
	end

	always_comb begin
		case (mode_s1)
			tlem_pkg::MODE_SPACE: begin
				x2 = 26'(prod_s1 >> 7);
				m2 = tlem_pkg::RECIP9;
			end
			tlem_pkg::MODE_NBSP: begin
				x2 = 26'(prod_s1 >> 9);
				m2 = tlem_pkg::RECIP9;
			end
			tlem_pkg::MODE_HEIGHT: begin
				x2 = prod_s1[25:0];
				m2 = 19'(y_scale);
			end
			default: begin
				x2 = '0;
				m2 = '0;
			end
		endcase
	end

	assign prod2     = 45'(x2) * 45'(m2);
	assign height_sh = 37'(prod2 >> 8);

	always_comb begin
		case (mode_s1)
			tlem_pkg::MODE_SPACE,
			tlem_pkg::MODE_NBSP:   res_d = 32'(prod2 >> tlem_pkg::RECIP_SHIFT);
			tlem_pkg::MODE_HEIGHT: res_d = (|height_sh[36:32]) ? '1 : height_sh[31:0];
			default:               res_d = 32'(prod_s1 >> 8);
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.div_en) begin
			res_s2 <= res_d;
		end
	end

	assign result = res_s2;

endmodule

// ----- hdl/tlem_chk.sv -----
// ----------------------------------------------------------------------------
// tlem_chk
// Port-level checks of the text line extent measurement block.
// ----------------------------------------------------------------------------
module tlem_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_stall,
	input logic [1:0]                    opcode,
	input logic                          rsp_valid,
	input logic                          rsp_stall,
	input logic [1:0]                    result_kind,
	input logic [tlem_pkg::OUT_W-1:0]    pen_x,
	input logic                          glyph_visible,
	input logic [tlem_pkg::OUT_W-1:0]    line_width,
	input logic [tlem_pkg::HEIGHT_W-1:0] text_height,
	input logic                          last
);

	// A stalled result holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(result_kind) &&
		$stable(pen_x) && $stable(line_width))
		else $error("stalled result changed");

	// Only the text-ended result carries the last flag.
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (last == (result_kind == tlem_pkg::KIND_TEXT)))
		else $error("last flag does not match result kind");

	// Character results carry no text height.
	a_char_height: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (result_kind == tlem_pkg::KIND_CHAR) |-> (text_height == '0))
		else $error("character result with nonzero text height");

	// Line and text results never mark a glyph visible.
	a_line_vis: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (result_kind != tlem_pkg::KIND_CHAR) |-> !glyph_visible)
		else $error("line result with glyph visible");

	// A table load completes in the cycle it is taken.
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (opcode == tlem_pkg::OP_LOAD) |=> !req_stall)
		else $error("block busy after a table load");

endmodule

bind text_line_extent_measure tlem_chk u_tlem_chk (.*);
